FILE: src/sfc_pkg.sv
package sfc_pkg;

  // geometry of the item and of the plane registers
  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 20;
  localparam int NORM_W     = 14;
  localparam int VEC_W      = 3 * COORD_W;
  localparam int PLANE_W    = 62;
  localparam int CFG_IDX_W  = 3;

  // internal widths, all exact
  localparam int PROD_W = 2 * COORD_W;          // coordinate products
  localparam int WC_W   = 41;                   // world centre, 2^-16
  localparam int LEN2_W = 40;                   // squared column length, 2^-16
  localparam int HALF_W = LEN2_W / 2;           // split for the radius product
  localparam int PN_W   = NORM_W + WC_W;        // normal times centre
  localparam int DIST_W = 56;                   // plane distance, 2^-28
  localparam int MH_W   = DIST_W / 2;           // split for the distance square
  localparam int SQ_W   = 2 * DIST_W;           // squared distance, 2^-56
  localparam int RS_W   = 2 * LEN2_W;           // r^2 * s^2, 2^-32
  localparam int RS_SH  = 24;                   // aligns r^2 * s^2 to 2^-56

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CULL_ENABLE = 3'd0,
    REG_PLANE_A     = 3'd1,
    REG_PLANE_B     = 3'd2,
    REG_PLANE_C     = 3'd3,
    REG_PLANE_D     = 3'd4,
    REG_PLANE_E     = 3'd5,
    REG_PLANE_F     = 3'd6
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;               // x lowest
  typedef logic signed [WC_W-1:0] wc_t;
  typedef wc_t [2:0] wc_vec_t;

  // plane register: nx lowest, then ny, nz, d
  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [NORM_W-1:0]  nz;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nx;
  } plane_t;

endpackage

FILE: src/sfc_plane_test.sv
module sfc_plane_test import sfc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  wc_vec_t           wc,
  input  plane_t            plane,
  input  logic [RS_W-1:0]   rs,
  output logic              cull
);

  logic signed [PN_W-1:0]   pn [3];
  logic signed [DIST_W-1:0] sdist;
  logic                     neg5;
  logic [DIST_W-1:0]        mag;
  logic                     neg6;
  logic [2*MH_W-1:0]        sq_hh;
  logic [2*MH_W-1:0]        sq_hl;
  logic [2*MH_W-1:0]        sq_ll;
  logic [SQ_W-1:0]          sq;
  logic [SQ_W-1:0]          rs_wide;

  // normal components times world centre
  always_ff @(posedge clk) begin
    if (en) begin
      pn[0] <= $signed(plane.nx) * $signed(wc[0]);
      pn[1] <= $signed(plane.ny) * $signed(wc[1]);
      pn[2] <= $signed(plane.nz) * $signed(wc[2]);
    end
  end

  // signed distance n.c + d
  always_ff @(posedge clk) begin
    if (en) begin
      sdist <= DIST_W'(pn[0]) + DIST_W'(pn[1]) + DIST_W'(pn[2])
             + $signed({{(DIST_W-COORD_W-20){plane.d[COORD_W-1]}}, plane.d, 20'd0});
    end
  end

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      neg5 <= sdist[DIST_W-1];
      mag  <= sdist[DIST_W-1] ? DIST_W'(-sdist) : DIST_W'(sdist);
    end
  end

  // square of the magnitude as three partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg6  <= neg5;
      sq_hh <= mag[DIST_W-1:MH_W] * mag[DIST_W-1:MH_W];
      sq_hl <= mag[DIST_W-1:MH_W] * mag[MH_W-1:0];
      sq_ll <= mag[MH_W-1:0] * mag[MH_W-1:0];
    end
  end

  // outside when below the plane and farther than the scaled radius
  assign sq      = (SQ_W'(sq_hh) << (2 * MH_W)) + (SQ_W'(sq_hl) << (MH_W + 1))
                 + SQ_W'(sq_ll);
  assign rs_wide = SQ_W'(rs) << RS_SH;
  assign cull    = neg6 && (sq > rs_wide);

endmodule

FILE: src/sphere_frustum_cull_unit.sv
// Bounding-sphere frustum cull, one object per item.
// Input item on s_axis: a 3x4 affine transform and an object-space bounding
// sphere. The centre is moved to world space, the radius scaled by the
// longest linear column, and the sphere tested against six planes; the item
// on m_axis says whether the object is visible.
// Configuration: cfg_we writes cfg_data to register cfg_index in the same
// cycle (0 cull enable, 1..6 planes a..f). Write only while the unit is idle.
// Throughput: one item per cycle unless the receiver stalls, through seven
// register stages, each holding one level of multiplies, adds or compares.
// The squared distance and squared scaled radius are compared exactly, so no
// square root is taken.
// Reset clears the pipeline valid bits, cull enable (every object visible)
// and the planes. When the receiver stalls the whole pipeline holds,
// s_axis_tready follows m_axis_tready while an output item is waiting, and
// no item is lost or repeated.
module sphere_frustum_cull_unit import sfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // linear_col0[59:0], linear_col1[119:60], linear_col2[179:120],
  // translation[239:180], local_center[299:240], local_radius[319:300]
  input  logic [319:0]         s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // visible[0], zero pad [7:1]
  output logic [7:0]           m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PLANE_W-1:0]   cfg_data
);

  logic                     cull_enable;
  plane_t                   planes [NUM_PLANES];
  vec_t                     col [3];
  vec_t                     trn;
  vec_t                     ctr;
  logic [COORD_W-1:0]       radius;
  logic                     adv;
  logic [6:0]               vld;
  logic signed [PROD_W-1:0] prod [3][3];
  coord_t                   trn1 [3];
  logic [PROD_W-2:0]        esq [3][3];
  logic [PROD_W-1:0]        rr1;
  wc_vec_t                  wc;
  logic [LEN2_W-1:0]        len2 [3];
  logic [LEN2_W-1:0]        rr2;
  logic [LEN2_W-1:0]        s2;
  logic [LEN2_W-1:0]        rr3;
  logic [LEN2_W-1:0]        s2_max01;
  logic [2*HALF_W-1:0]      rp_hh;
  logic [2*HALF_W-1:0]      rp_hl;
  logic [2*HALF_W-1:0]      rp_lh;
  logic [2*HALF_W-1:0]      rp_ll;
  logic [RS_W-1:0]          rs5;
  logic [RS_W-1:0]          rs6;
  logic [NUM_PLANES-1:0]    cull;
  logic                     visible;
  logic                     visible_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cull_enable <= 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes[p] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CULL_ENABLE: cull_enable <= cfg_data[0];
        REG_PLANE_A:     planes[0] <= plane_t'(cfg_data);
        REG_PLANE_B:     planes[1] <= plane_t'(cfg_data);
        REG_PLANE_C:     planes[2] <= plane_t'(cfg_data);
        REG_PLANE_D:     planes[3] <= plane_t'(cfg_data);
        REG_PLANE_E:     planes[4] <= plane_t'(cfg_data);
        REG_PLANE_F:     planes[5] <= plane_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // item fields
  assign col[0] = vec_t'(s_axis_tdata[VEC_W-1:0]);
  assign col[1] = vec_t'(s_axis_tdata[2*VEC_W-1:VEC_W]);
  assign col[2] = vec_t'(s_axis_tdata[3*VEC_W-1:2*VEC_W]);
  assign trn    = vec_t'(s_axis_tdata[4*VEC_W-1:3*VEC_W]);
  assign ctr    = vec_t'(s_axis_tdata[5*VEC_W-1:4*VEC_W]);
  assign radius = s_axis_tdata[5*VEC_W+COORD_W-1:5*VEC_W];

  // whole pipeline moves together; the last stage is the output register
  assign adv           = !vld[6] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], s_axis_tvalid};
    end
  end

  // stage 1: transform products, column squares, radius square
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        trn1[k] <= trn[k];
        for (int i = 0; i < 3; i++) begin
          prod[k][i] <= $signed(col[i][k]) * $signed(ctr[i]);
          esq[i][k]  <= (PROD_W-1)'($signed(col[i][k]) * $signed(col[i][k]));
        end
      end
      rr1 <= radius * radius;
    end
  end

  // stage 2: world centre and squared column lengths
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        wc[k] <= WC_W'(prod[k][0]) + WC_W'(prod[k][1]) + WC_W'(prod[k][2])
               + $signed({{(WC_W-COORD_W-8){trn1[k][COORD_W-1]}}, trn1[k], 8'd0});
      end
      for (int i = 0; i < 3; i++) begin
        len2[i] <= LEN2_W'(esq[i][0]) + LEN2_W'(esq[i][1]) + LEN2_W'(esq[i][2]);
      end
      rr2 <= rr1;
    end
  end

  // stage 3: largest squared column length
  assign s2_max01 = (len2[1] > len2[0]) ? len2[1] : len2[0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2  <= (len2[2] > s2_max01) ? len2[2] : s2_max01;
      rr3 <= rr2;
    end
  end

  // stage 4: partial products of r^2 * s^2
  always_ff @(posedge clk) begin
    if (adv) begin
      rp_hh <= rr3[LEN2_W-1:HALF_W] * s2[LEN2_W-1:HALF_W];
      rp_hl <= rr3[LEN2_W-1:HALF_W] * s2[HALF_W-1:0];
      rp_lh <= rr3[HALF_W-1:0] * s2[LEN2_W-1:HALF_W];
      rp_ll <= rr3[HALF_W-1:0] * s2[HALF_W-1:0];
    end
  end

  // stages 5 and 6: sum of the radius partial products, then a registered copy
  always_ff @(posedge clk) begin
    if (adv) begin
      rs5 <= (RS_W'(rp_hh) << (2 * HALF_W))
           + ((RS_W'(rp_hl) + RS_W'(rp_lh)) << HALF_W) + RS_W'(rp_ll);
      rs6 <= rs5;
    end
  end

  // per-plane distance tests, stages 3 to 6
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    sfc_plane_test u_plane (
      .clk   (clk),
      .en    (adv),
      .wc    (wc),
      .plane (planes[p]),
      .rs    (rs6),
      .cull  (cull[p])
    );
  end

  // stage 7: output register
  assign visible_next = !cull_enable || !(|cull);

  always_ff @(posedge clk) begin
    if (adv) begin
      visible <= visible_next;
    end
  end

  assign m_axis_tdata = {7'd0, visible};

endmodule

FILE: src/sfc_checker.sv
module sfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item valid right after reset");

  // a stalled output item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed or dropped");

  // input side only waits while a finished item is refused
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // pad bits above the visible flag stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("output pad bits not zero");

endmodule

bind sphere_frustum_cull_unit sfc_checker u_sfc_checker (.*);

FILE: tb/sv/tb_sphere_frustum_cull_unit.sv
`timescale 1ns / 1ps

module tb_sphere_frustum_cull_unit;
  import sfc_pkg::*;

  localparam int ITEM_W      = 5 * VEC_W + COORD_W;
  localparam int ONE         = 256;          // 1.0 in Q12.8
  localparam int NORM_ONE    = 4096;         // 1.0 in Q2.12
  localparam int BOX_HALF    = 100 * ONE;    // half size of the directed box frustum
  localparam int COORD_MAX   = 524287;
  localparam int COORD_MIN   = -524288;
  localparam int NORM_MAX    = 8191;
  localparam int NORM_MIN    = -8192;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PRINT_CAP   = 200;

  typedef enum {CFG_AT_RESET, CFG_ON_NO_PLANES, CFG_BOX, CFG_EXTREME} cfg_setting_t;
  typedef enum {PH_FRUSTUM, PH_DISABLED, PH_RAW_PLANES, PH_EXTREME_PLANES} phase_kind_t;

  typedef struct {
    cfg_setting_t      setting;
    logic [ITEM_W-1:0] obj;
    bit                typed;
    logic              vis;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // linear_col0[59:0], linear_col1[119:60], linear_col2[179:120],
  // translation[239:180], local_center[299:240], local_radius[319:300]
  logic [ITEM_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // visible[0], zero pad [7:1]
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CULL_ENABLE;
  logic [PLANE_W-1:0]   cfg_data = '0;

  // predictor copy of the registers
  logic   cull_on;
  plane_t frustum [NUM_PLANES];

  logic     visible_q [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       rx_mode = 0;
  int       rx_left = 0;
  int       rx_tick = 0;
  bit       hold_rx_ready = 1'b0;

  sphere_frustum_cull_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sphere_frustum_cull_unit test failed");
      $finish;
    end
  end

  // packing helpers
  function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
    return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
  endfunction

  function automatic logic [PLANE_W-1:0] plane(input int nx, input int ny, input int nz,
                                               input int d);
    return {d[COORD_W-1:0], nz[NORM_W-1:0], ny[NORM_W-1:0], nx[NORM_W-1:0]};
  endfunction

  function automatic logic [ITEM_W-1:0] obj_item(input logic [VEC_W-1:0] c0,
      input logic [VEC_W-1:0] c1, input logic [VEC_W-1:0] c2, input logic [VEC_W-1:0] tr,
      input logic [VEC_W-1:0] ctr, input int rad);
    return {rad[COORD_W-1:0], ctr, tr, c2, c1, c0};
  endfunction

  function automatic longint crd(input vec_t v, input int k);
    return longint'(signed'(v[k]));
  endfunction

  function automatic int srand(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  // visibility of one object against the current frustum, exact
  function automatic logic object_visible(input logic [ITEM_W-1:0] obj);
    vec_t        col [4];
    vec_t        ctr;
    longint      wc [3];
    longint      len2, s2, pdist, nx, ny, nz, d;
    logic [127:0] rr, rs, mag, sq;
    plane_t      p;
    logic        vis;
    if (!cull_on) return 1'b1;
    for (int i = 0; i < 4; i++) col[i] = obj[i*VEC_W +: VEC_W];
    ctr = obj[4*VEC_W +: VEC_W];
    rr  = obj[5*VEC_W +: COORD_W];
    // world centre at 2^-16
    for (int k = 0; k < 3; k++)
      wc[k] = crd(col[0], k) * crd(ctr, 0) + crd(col[1], k) * crd(ctr, 1)
            + crd(col[2], k) * crd(ctr, 2) + crd(col[3], k) * 256;
    // largest squared column length
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      len2 = 0;
      for (int k = 0; k < 3; k++) len2 += crd(col[i], k) * crd(col[i], k);
      if (len2 > s2) s2 = len2;
    end
    // (r*s)^2 aligned to 2^-56
    rs = rr * rr;
    rs = rs * s2;
    rs = rs << RS_SH;
    vis = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      p  = frustum[i];
      nx = longint'(signed'(p.nx));
      ny = longint'(signed'(p.ny));
      nz = longint'(signed'(p.nz));
      d  = longint'(signed'(p.d));
      pdist = nx * wc[0] + ny * wc[1] + nz * wc[2] + (d <<< 20);
      if (pdist < 0) begin
        mag = -pdist;
        sq  = mag * mag;
        if (sq > rs) vis = 1'b0;
      end
    end
    return vis;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log short when things go badly wrong
    if (mismatch_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // register write, called at a falling edge
  task automatic write_reg(input cfg_reg_t idx, input logic [PLANE_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_CULL_ENABLE) cull_on = val[0];
    else frustum[idx - REG_PLANE_A] = val;
  endtask

  task automatic write_enable(input logic en);
    logic [63:0] junk;
    // upper bits carry noise, only bit 0 counts
    junk    = {$urandom, $urandom};
    junk[0] = en;
    write_reg(REG_CULL_ENABLE, junk[PLANE_W-1:0]);
  endtask

  task automatic write_plane(input int i, input logic [PLANE_W-1:0] val);
    write_reg(cfg_reg_t'(REG_PLANE_A + i), val);
  endtask

  // wait for the pipeline to empty, at a falling edge
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (visible_q.size() != 0) @(negedge clk);
  endtask

  // offer one item in bursts with gaps between them
  task automatic send_obj(input logic [ITEM_W-1:0] obj, input logic want);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tdata  = obj;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    visible_q.insert(visible_q.size(), want);
    @(negedge clk);
  endtask

  task automatic apply_setting(input cfg_setting_t setting);
    case (setting)
      CFG_ON_NO_PLANES: begin
        write_enable(1'b1);
      end
      CFG_BOX: begin
        write_plane(0, plane( NORM_ONE, 0, 0, BOX_HALF));
        write_plane(1, plane(-NORM_ONE, 0, 0, BOX_HALF));
        write_plane(2, plane(0,  NORM_ONE, 0, BOX_HALF));
        write_plane(3, plane(0, -NORM_ONE, 0, BOX_HALF));
        write_plane(4, plane(0, 0,  NORM_ONE, BOX_HALF));
        write_plane(5, plane(0, 0, -NORM_ONE, BOX_HALF));
      end
      CFG_EXTREME: begin
        write_plane(0, plane(NORM_MIN, 0, 0, COORD_MIN));
        write_plane(1, '1);
        write_plane(2, plane(NORM_MAX, NORM_MAX, NORM_MAX, COORD_MAX));
        write_plane(3, plane(NORM_MIN, NORM_MIN, NORM_MIN, COORD_MIN));
        write_plane(4, '0);
        write_plane(5, plane(NORM_MAX, NORM_MIN, 0, 0));
      end
      default: begin
      end
    endcase
  endtask

  function automatic void add_row(input cfg_setting_t setting, input logic [ITEM_W-1:0] obj,
                                  input bit typed, input logic vis);
    dir_row_t row;
    row.setting = setting;
    row.obj     = obj;
    row.typed   = typed;
    row.vis     = vis;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void fill_directed();
    logic [VEC_W-1:0] ix, iy, iz, zv, vmax, vmin;
    ix   = vec3(ONE, 0, 0);
    iy   = vec3(0, ONE, 0);
    iz   = vec3(0, 0, ONE);
    zv   = '0;
    vmax = vec3(COORD_MAX, COORD_MAX, COORD_MAX);
    vmin = vec3(COORD_MIN, COORD_MIN, COORD_MIN);
    // culling off after reset: always visible
    add_row(CFG_AT_RESET, '0, 1, 1'b1);
    add_row(CFG_AT_RESET, '1, 1, 1'b1);
    add_row(CFG_AT_RESET, obj_item(vmax, vmax, vmax, vmax, vmax, COORD_MAX * 2 + 1), 1, 1'b1);
    add_row(CFG_AT_RESET, obj_item(vmin, vmin, vmin, vmin, vmin, 0), 1, 1'b1);
    // enabled but all planes zero: nothing culled
    add_row(CFG_ON_NO_PLANES, obj_item(ix, iy, iz, zv, vmin, 0), 1, 1'b1);
    add_row(CFG_ON_NO_PLANES, '1, 1, 1'b1);
    add_row(CFG_ON_NO_PLANES, obj_item(vmax, vmax, vmax, vmax, vmax, 0), 1, 1'b1);
    // axis box of half size 100
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, zv, ONE), 1, 1'b1);
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, vec3(-200 * ONE, 0, 0), 0), 1, 1'b0);
    // radius just reaching the plane, then one step short
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, vec3(-200 * ONE, 0, 0), 100 * ONE), 0, 1'b0);
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, vec3(-200 * ONE, 0, 0), 100 * ONE - 1), 0, 1'b0);
    // zero radius on the plane and just outside it
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, vec3(-BOX_HALF, 0, 0), 0), 0, 1'b0);
    add_row(CFG_BOX, obj_item(ix, iy, iz, zv, vec3(-BOX_HALF - 1, 0, 0), 0), 0, 1'b0);
    // degenerate transform: scale zero, centre from translation alone
    add_row(CFG_BOX, obj_item(zv, zv, zv, zv, vmax, COORD_MAX), 0, 1'b0);
    add_row(CFG_BOX, obj_item(zv, zv, zv, vec3(300 * ONE, 0, 0), vmax, COORD_MAX), 0, 1'b0);
    // stretched column, sphere touching the plane after scaling
    add_row(CFG_BOX, obj_item(vec3(2 * ONE, 0, 0), iy, iz, zv, vec3(-60 * ONE, 0, 0),
                              10 * ONE), 0, 1'b0);
    add_row(CFG_BOX, obj_item(ix, iy, iz, vec3(150 * ONE, 0, 0), vec3(-150 * ONE, 0, 0), 0),
            0, 1'b0);
    add_row(CFG_BOX, obj_item(iy, vec3(-ONE, 0, 0), iz, zv, vec3(0, 150 * ONE, 0), ONE),
            0, 1'b0);
    add_row(CFG_BOX, obj_item(vmax, vmax, vmax, vmax, vmax, COORD_MAX * 2 + 1), 0, 1'b0);
    add_row(CFG_BOX, obj_item(vmin, vmin, vmin, vmin, vmin, 0), 0, 1'b0);
    // extreme plane values
    add_row(CFG_EXTREME, '1, 0, 1'b0);
    add_row(CFG_EXTREME, obj_item(vmax, vmax, vmax, vmax, vmax, 0), 0, 1'b0);
    add_row(CFG_EXTREME, obj_item(ix, iy, iz, zv, zv, 0), 0, 1'b0);
    add_row(CFG_EXTREME, obj_item(vmin, vmin, vmin, vmin, vmin, COORD_MAX * 2 + 1), 0, 1'b0);
  endfunction

  function automatic logic [ITEM_W-1:0] raw_object();
    logic [ITEM_W-1:0] obj;
    for (int w = 0; w < ITEM_W / 32; w++) obj[w*32 +: 32] = $urandom;
    return obj;
  endfunction

  // plausible object: near-diagonal transform, centre around the origin
  function automatic logic [ITEM_W-1:0] scene_object();
    logic [VEC_W-1:0] col [3];
    int               comp [3];
    int               rad;
    bit               flat;
    flat = ($urandom_range(0, 15) == 0);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) comp[k] = (k == i) ? srand(768) : srand(96);
      col[i] = flat ? '0 : vec3(comp[0], comp[1], comp[2]);
    end
    rad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30 * ONE);
    return obj_item(col[0], col[1], col[2],
                    vec3(srand(200 * ONE), srand(200 * ONE), srand(200 * ONE)),
                    vec3(srand(40 * ONE), srand(40 * ONE), srand(40 * ONE)), rad);
  endfunction

  function automatic int ext_val(input int w);
    case ($urandom_range(0, 3))
      0:       return -(1 << (w - 1));
      1:       return (1 << (w - 1)) - 1;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  task automatic configure_phase(input phase_kind_t kind);
    logic [63:0] bits;
    for (int i = 0; i < NUM_PLANES; i++) begin
      case (kind)
        PH_FRUSTUM: begin
          // now and then a plane left at zero
          if ($urandom_range(0, 7) == 0) write_plane(i, '0);
          else write_plane(i, plane(srand(NORM_ONE), srand(NORM_ONE), srand(NORM_ONE),
                                    srand(150 * ONE)));
        end
        PH_EXTREME_PLANES: begin
          write_plane(i, plane(ext_val(NORM_W), ext_val(NORM_W), ext_val(NORM_W),
                               ext_val(COORD_W)));
        end
        default: begin
          bits = {$urandom, $urandom};
          write_plane(i, bits[PLANE_W-1:0]);
        end
      endcase
    end
    write_enable(kind != PH_DISABLED);
  endtask

  // receiver stall patterns
  always @(negedge clk) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    if (hold_rx_ready) m_axis_tready = 1'b1;
    else begin
      case (rx_mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = $urandom_range(0, 1);
        2:       m_axis_tready = ($urandom_range(0, 7) == 0);
        default: m_axis_tready = (rx_tick % 4 != 3);
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    logic want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (visible_q.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected, visible=%0b",
                                  m_axis_tdata[0]));
      end else begin
        want = visible_q.pop_front();
        if (m_axis_tdata[0] !== want)
          report_mismatch($sformatf("visible got %0b want %0b", m_axis_tdata[0], want));
      end
    end
  end

  // stimulus
  initial begin
    cfg_setting_t cur;
    phase_kind_t  kind;
    logic [ITEM_W-1:0] obj;
    cull_on = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) frustum[i] = '0;
    fill_directed();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed table
    cur = CFG_AT_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur) begin
        drain_results();
        apply_setting(dir_rows[i].setting);
        cur = dir_rows[i].setting;
      end
      send_obj(dir_rows[i].obj,
               dir_rows[i].typed ? dir_rows[i].vis : object_visible(dir_rows[i].obj));
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      kind = (ph == 1) ? PH_DISABLED :
             (ph == 3) ? PH_RAW_PLANES :
             (ph == 5) ? PH_EXTREME_PLANES : PH_FRUSTUM;
      configure_phase(kind);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off until the pipeline is empty
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
        obj = ($urandom_range(0, 4) == 0) ? raw_object() : scene_object();
        send_obj(obj, object_visible(obj));
      end
    end

    drain_results();
    hold_rx_ready = 1'b1;
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0) $display("sphere_frustum_cull_unit test passed");
    else $display("sphere_frustum_cull_unit test failed");
    $finish;
  end

endmodule
